/* hdl/tdl_pkg.sv */
// ----------------------------------------------------------------------------
// Tree distance LCA package
// Shared types and fixed field widths for the binary-lifting LCA unit.
// ----------------------------------------------------------------------------
package tdl_pkg;

    // Fixed widths of the word fields.
    localparam int NODE_W  = 16;
    localparam int DEPTH_W = 16;
    localparam int DIST_W  = 32;
    localparam int INFO_W  = DEPTH_W + DIST_W;

    // Operation codes of an input word.
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [15:0] {
        S_IDLE     = 16'b0000_0000_0000_0001,
        S_MOD      = 16'b0000_0000_0000_0010,
        S_ADD_INFO = 16'b0000_0000_0000_0100,
        S_ADD_WRI  = 16'b0000_0000_0000_1000,
        S_ADD_RD   = 16'b0000_0000_0001_0000,
        S_ADD_WR   = 16'b0000_0000_0010_0000,
        S_Q_INFO   = 16'b0000_0000_0100_0000,
        S_Q_SWAP   = 16'b0000_0000_1000_0000,
        S_LIFT     = 16'b0000_0001_0000_0000,
        S_LIFT_WR  = 16'b0000_0010_0000_0000,
        S_DESC     = 16'b0000_0100_0000_0000,
        S_DESC_CMP = 16'b0000_1000_0000_0000,
        S_ANC      = 16'b0001_0000_0000_0000,
        S_ANC_WR   = 16'b0010_0000_0000_0000,
        S_DIST     = 16'b0100_0000_0000_0000,
        S_OUT      = 16'b1000_0000_0000_0000
    } t_state;

endpackage

/* hdl/tdl_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, each read registered.
// ----------------------------------------------------------------------------
module tdl_ram #(
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_a,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [2**ADDR_W];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write port and registered reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* hdl/tree_distance_lca_lifting_unit.sv */
// ----------------------------------------------------------------------------
// Tree distance LCA lifting unit
// Add: index reduction when NODES is below 65536 and not a power of two, then
//   the node info and level-0 ancestor, then one read and one write per higher level.
// Query: same reduction, node info, lift (a read per set bit of the depth difference)
//   + descent (up to LEVELS comparisons) + final parent steps, distance and word.
// One word at a time: a new word is taken only while the sequencer is idle.
// Reset clears the sequencer and output valid; tables are undefined until
//   written, and there is no clearing pass.
// ----------------------------------------------------------------------------
module tree_distance_lca_lifting_unit
    import tdl_pkg::*;
#(
    parameter int NODES  = 65536,
    parameter int LEVELS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_operation,
    input  logic [NODE_W-1:0]   i_node,
    input  logic [NODE_W-1:0]   i_parent,
    input  logic [NODE_W-1:0]   i_weight,
    input  logic [NODE_W-1:0]   i_other_node,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [NODE_W-1:0]   o_ancestor,
    output logic [DIST_W-1:0]   o_path_length
);

    // Node index and level widths.
    localparam int IW = (NODES >= 65536) ? NODE_W : $clog2(NODES);
    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ANC_AW = LW + IW;
    localparam bit NEED_MOD = (NODES < 65536) && ((NODES & (NODES - 1)) != 0);
    localparam logic [LW-1:0] LAST_LVL = LW'(LEVELS - 1);

    // Reciprocal of NODES, rounded up, for the remainder of a 16-bit number.
    localparam logic [63:0] RECIP_FULL = ((64'd1 << 32) + 64'(NODES) - 64'd1) / 64'(NODES);
    localparam logic [31:0] MOD_RECIP  = NEED_MOD ? RECIP_FULL[31:0] : 32'd0;
    localparam logic [31:0] MOD_N      = 32'(NODES);

    t_state              r_state, n_state;
    logic [3:0]          r_cnt, n_cnt;
    logic                r_op, n_op;
    logic [NODE_W-1:0]   r_raw_a, n_raw_a;
    logic [NODE_W-1:0]   r_raw_p, n_raw_p;
    logic [NODE_W-1:0]   r_raw_b, n_raw_b;
    logic [NODE_W-1:0]   r_w, n_w;
    logic [IW-1:0]       r_x, n_x;
    logic [IW-1:0]       r_y, n_y;
    logic [IW-1:0]       r_p, n_p;
    logic [LW-1:0]       r_lvl, n_lvl;
    logic [LEVELS-1:0]   r_diff, n_diff;
    logic [DIST_W-1:0]   r_acc, n_acc;
    logic [31:0]         r_frac, n_frac;
    logic                r_out_valid, n_out_valid;
    logic [NODE_W-1:0]   r_out_anc, n_out_anc;
    logic [DIST_W-1:0]   r_out_path, n_out_path;

    // RAM ports.
    logic                anc_we;
    logic [ANC_AW-1:0]   anc_waddr, anc_raddr_a, anc_raddr_b;
    logic [IW-1:0]       anc_wdata, anc_rdata_a, anc_rdata_b;
    logic                info_we;
    logic [IW-1:0]       info_waddr, info_raddr_a, info_raddr_b;
    logic [INFO_W-1:0]   info_wdata, info_rdata_a, info_rdata_b;

    logic [DEPTH_W-1:0]  depth_a, depth_b;
    logic [DIST_W-1:0]   dist_a, dist_b;
    logic [DEPTH_W-1:0]  depth_diff;
    logic [LW-1:0]       lvl_m1;

    // Shared multiplier of the index reduction.
    logic [NODE_W-1:0]   mod_src;
    logic [31:0]         mul_a, mul_b;
    logic [63:0]         mul_p;

    // Ancestor table: level in the upper address bits, node in the lower.
    tdl_ram #(.WIDTH(IW), .ADDR_W(ANC_AW)) u_anc_ram (
        .i_clk     (i_clk),
        .i_we      (anc_we),
        .i_waddr   (anc_waddr),
        .i_wdata   (anc_wdata),
        .i_raddr_a (anc_raddr_a),
        .i_raddr_b (anc_raddr_b),
        .o_rdata_a (anc_rdata_a),
        .o_rdata_b (anc_rdata_b)
    );

    // Node info: root distance over depth.
    tdl_ram #(.WIDTH(INFO_W), .ADDR_W(IW)) u_info_ram (
        .i_clk     (i_clk),
        .i_we      (info_we),
        .i_waddr   (info_waddr),
        .i_wdata   (info_wdata),
        .i_raddr_a (info_raddr_a),
        .i_raddr_b (info_raddr_b),
        .o_rdata_a (info_rdata_a),
        .o_rdata_b (info_rdata_b)
    );

    assign depth_a = info_rdata_a[DEPTH_W-1:0];
    assign dist_a  = info_rdata_a[INFO_W-1:DEPTH_W];
    assign depth_b = info_rdata_b[DEPTH_W-1:0];
    assign dist_b  = info_rdata_b[INFO_W-1:DEPTH_W];
    assign lvl_m1  = r_lvl - LW'(1);
    assign depth_diff = (depth_a < depth_b) ? (depth_b - depth_a) : (depth_a - depth_b);

    // An even step multiplies the raw number by the reciprocal, an odd step
    // scales the kept fraction by NODES.
    assign mod_src = (r_cnt[2:1] == 2'd0) ? r_raw_a :
                     ((r_cnt[2:1] == 2'd1) ? r_raw_p : r_raw_b);
    assign mul_a   = r_cnt[0] ? r_frac : {16'd0, mod_src};
    assign mul_b   = r_cnt[0] ? MOD_N : MOD_RECIP;
    assign mul_p   = 64'(mul_a) * 64'(mul_b);

    // Sequencer and datapath next state.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_op        = r_op;
        n_raw_a     = r_raw_a;
        n_raw_p     = r_raw_p;
        n_raw_b     = r_raw_b;
        n_w         = r_w;
        n_x         = r_x;
        n_y         = r_y;
        n_p         = r_p;
        n_lvl       = r_lvl;
        n_diff      = r_diff;
        n_acc       = r_acc;
        n_frac      = r_frac;
        n_out_valid = r_out_valid;
        n_out_anc   = r_out_anc;
        n_out_path  = r_out_path;

        anc_we       = 1'b0;
        anc_waddr    = '0;
        anc_wdata    = '0;
        anc_raddr_a  = '0;
        anc_raddr_b  = '0;
        info_we      = 1'b0;
        info_waddr   = '0;
        info_wdata   = '0;
        info_raddr_a = '0;
        info_raddr_b = '0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state) inside
            S_IDLE: begin
                if (i_valid) begin
                    n_op    = i_operation;
                    n_w     = i_weight;
                    n_raw_a = i_node;
                    n_raw_p = i_parent;
                    n_raw_b = i_other_node;
                    n_cnt   = '0;
                    if (NEED_MOD) begin
                        n_x     = '0;
                        n_p     = '0;
                        n_y     = '0;
                        n_state = S_MOD;
                    end else begin
                        n_x     = i_node[IW-1:0];
                        n_p     = i_parent[IW-1:0];
                        n_y     = i_other_node[IW-1:0];
                        n_state = (i_operation == OP_ADD) ? S_ADD_INFO : S_Q_INFO;
                    end
                end
            end
            S_MOD: begin
                // Reduce the three node numbers modulo NODES, two steps each.
                if (!r_cnt[0]) begin
                    n_frac = mul_p[31:0];
                end else if (r_cnt[2:1] == 2'd0) begin
                    n_x = mul_p[32 +: IW];
                end else if (r_cnt[2:1] == 2'd1) begin
                    n_p = mul_p[32 +: IW];
                end else begin
                    n_y = mul_p[32 +: IW];
                end
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd5) begin
                    n_state = (r_op == OP_ADD) ? S_ADD_INFO : S_Q_INFO;
                end
            end
            S_ADD_INFO: begin
                info_raddr_a = r_p;
                n_state      = S_ADD_WRI;
            end
            S_ADD_WRI: begin
                // Depth and distance from the parent, and the first ancestor.
                info_we    = 1'b1;
                info_waddr = r_x;
                if (r_p != r_x) begin
                    info_wdata = {dist_a + {16'd0, r_w}, depth_a + 16'd1};
                end
                anc_we    = 1'b1;
                anc_waddr = {LW'(0), r_x};
                anc_wdata = r_p;
                n_y       = r_p;
                n_lvl     = LW'(1);
                n_state   = (LEVELS == 1) ? S_IDLE : S_ADD_RD;
            end
            S_ADD_RD: begin
                anc_raddr_a = {lvl_m1, r_y};
                n_state     = S_ADD_WR;
            end
            S_ADD_WR: begin
                // Entry at this level is the previous level applied twice.
                anc_we    = 1'b1;
                anc_waddr = {r_lvl, r_x};
                anc_wdata = anc_rdata_a;
                n_y       = anc_rdata_a;
                if (r_lvl == LAST_LVL) begin
                    n_state = S_IDLE;
                end else begin
                    n_lvl   = r_lvl + LW'(1);
                    n_state = S_ADD_RD;
                end
            end
            S_Q_INFO: begin
                info_raddr_a = r_x;
                info_raddr_b = r_y;
                n_state      = S_Q_SWAP;
            end
            S_Q_SWAP: begin
                // Put the deeper node in x and keep the depth difference.
                n_acc = dist_a + dist_b;
                if (depth_a < depth_b) begin
                    n_x = r_y;
                    n_y = r_x;
                end
                n_diff = LEVELS'(depth_diff);
                if (n_diff == '0) begin
                    n_lvl   = LAST_LVL;
                    n_state = S_DESC;
                end else begin
                    n_lvl   = '0;
                    n_state = S_LIFT;
                end
            end
            S_LIFT, S_LIFT_WR: begin
                if (r_state == S_LIFT && r_diff[0]) begin
                    anc_raddr_a = {r_lvl, r_x};
                    n_state     = S_LIFT_WR;
                end else begin
                    if (r_state == S_LIFT_WR) begin
                        n_x = anc_rdata_a;
                    end
                    n_diff = r_diff >> 1;
                    if (n_diff == '0) begin
                        n_lvl   = LAST_LVL;
                        n_state = S_DESC;
                    end else begin
                        n_lvl   = r_lvl + LW'(1);
                        n_state = S_LIFT;
                    end
                end
            end
            S_DESC: begin
                if (r_x == r_y) begin
                    n_state = S_ANC;
                end else begin
                    anc_raddr_a = {r_lvl, r_x};
                    anc_raddr_b = {r_lvl, r_y};
                    n_state     = S_DESC_CMP;
                end
            end
            S_DESC_CMP: begin
                if (anc_rdata_a != anc_rdata_b) begin
                    n_x = anc_rdata_a;
                    n_y = anc_rdata_b;
                end
                if (r_lvl == '0) begin
                    n_state = S_ANC;
                end else begin
                    n_lvl   = lvl_m1;
                    n_state = S_DESC;
                end
            end
            S_ANC: begin
                if (r_x == r_y) begin
                    info_raddr_a = r_x;
                    n_state      = S_DIST;
                end else begin
                    anc_raddr_a = {LW'(0), r_x};
                    n_state     = S_ANC_WR;
                end
            end
            S_ANC_WR: begin
                n_x     = anc_rdata_a;
                n_y     = anc_rdata_a;
                n_state = S_ANC;
            end
            S_DIST: begin
                n_acc   = r_acc - {dist_a[DIST_W-2:0], 1'b0};
                n_state = S_OUT;
            end
            S_OUT: begin
                // Load the output register once it is free.
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_anc   = NODE_W'(r_x);
                    n_out_path  = r_acc;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_op       <= n_op;
        r_raw_a    <= n_raw_a;
        r_raw_p    <= n_raw_p;
        r_raw_b    <= n_raw_b;
        r_w        <= n_w;
        r_x        <= n_x;
        r_y        <= n_y;
        r_p        <= n_p;
        r_lvl      <= n_lvl;
        r_diff     <= n_diff;
        r_acc      <= n_acc;
        r_frac     <= n_frac;
        r_out_anc  <= n_out_anc;
        r_out_path <= n_out_path;
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_ancestor    = r_out_anc;
    assign o_path_length = r_out_path;

`ifndef SYNTHESIS
    // A result word appears only from the output state.
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_OUT))
        else $error("result word raised outside the output state");

    // The lift loop runs only while depth bits remain.
    a_lift_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIFT) |-> (r_diff != '0))
        else $error("lift step with no depth difference left");

    // The final parent step merges both nodes.
    a_anc_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ANC_WR) |=> ((r_state == S_ANC) && (r_x == r_y)))
        else $error("nodes not merged after parent step");

    // No new word is taken while a query result is still being built.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIST) |=> (!o_ready && (r_state == S_OUT)))
        else $error("sequencer left distance step unexpectedly");
`endif

endmodule
